>>> hw/rtl/atsid_pkg.sv
// Shared types and codes for the array table search/insert/delete unit.
// Used by atsid_cell and the top level; no dependencies.
package atsid_pkg;

  localparam int DATA_W = 32;
  localparam int LOC_W  = 7;

  // Request operation codes
  typedef enum logic [1:0] {
    MODE_SEARCH = 2'd0,
    MODE_UPDATE = 2'd1,
    MODE_INSERT = 2'd2,
    MODE_DELETE = 2'd3
  } mode_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_BAD_LOC   = 2'd2,
    STAT_FULL      = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // Command broadcast to every cell of the row
  typedef struct packed {
    logic                     cmp;        // latch compare against key
    logic                     upd;        // overwrite first match
    logic                     ins;        // insert at loc, shift up
    logic                     del;        // remove first match, shift down
    logic [LOC_W-1:0]         loc;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] new_value;
  } cell_cmd_t;

endpackage

>>> hw/rtl/atsid_cell.sv
// One table cell: holds one element, its compare hit, and the
// first-match carry link. Depends on atsid_pkg.
module atsid_cell import atsid_pkg::*; #(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  logic                     clk,
  input  cell_cmd_t                cmd,
  input  logic [CW-1:0]            elem_count,
  input  logic signed [DATA_W-1:0] lower,
  input  logic signed [DATA_W-1:0] upper,
  input  logic                     before_in,
  output logic                     before_out,
  output logic                     first,
  output logic signed [DATA_W-1:0] data
);

  logic                     hit;
  logic signed [DATA_W-1:0] data_next;

  // Pass the "match seen below" carry to the next cell up
  assign before_out = before_in | hit;
  assign first      = hit & ~before_in;

  // Pick the next element value
  always_comb begin
    data_next = data;
    if (cmd.upd && first) begin
      data_next = cmd.new_value;
    end else if (cmd.ins) begin
      if (int'(cmd.loc) == IDX) begin
        data_next = cmd.new_value;
      end else if (IDX > int'(cmd.loc)) begin
        data_next = lower;
      end
    end else if (cmd.del && before_out) begin
      data_next = upper;
    end
  end

  // Hold element; capture compare on request accept
  always_ff @(posedge clk) begin
    data <= data_next;
    if (cmd.cmp) begin
      hit <= (IDX < int'(elem_count)) && (data == cmd.key);
    end
  end

endmodule

>>> hw/rtl/array_table_search_insert_delete_unit.sv
// Array table engine: a row of CAPACITY cells holding a compact table of
// signed 32-bit elements plus an element count.
// Request channel (req_valid/req_stall): mode, key, new_value, location.
// Response channel (rsp_valid/rsp_stall): status, index, count.
// On accept every cell registers the compare of its element against key;
// in the update state (ST_EXEC) a carry chain through the cells marks
// the first match and all cells update in parallel
// (overwrite, shift up for insert, shift down for delete).
// A new request is held off (req_stall) until the one before has
// made its update and left ST_EXEC.
// The response sits in an output register; a new request is accepted
// while it waits, but its update cycle holds until that beat is taken.
// Reset (rst, synchronous) empties the table and drops any pending
// response; cell contents are not cleared since cells at or above count
// are never read.
// Depends on atsid_pkg and atsid_cell.
module array_table_search_insert_delete_unit import atsid_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  output logic                     req_stall,
  input  logic [1:0]               mode,
  input  logic signed [DATA_W-1:0] key,
  input  logic signed [DATA_W-1:0] new_value,
  input  logic [LOC_W-1:0]         location,
  output logic                     rsp_valid,
  input  logic                     rsp_stall,
  output logic [1:0]               status,
  output logic [5:0]               index,
  output logic [6:0]               count
);

  localparam int IW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int LCW = (CW > LOC_W) ? CW : LOC_W;

  state_t                   state, state_next;
  mode_t                    mode_q;
  logic signed [DATA_W-1:0] value_q;
  logic [LOC_W-1:0]         loc_q;
  logic [CW-1:0]            elem_count, elem_count_next;

  logic                     accept, fire;
  logic                     found, loc_bad, is_full;
  logic [IW-1:0]            hit_index;
  status_t                  status_next;
  logic [5:0]               index_next;
  cell_cmd_t                cmd;

  logic [CAPACITY:0]        chain;
  logic [CAPACITY-1:0]      first_vec;
  logic signed [DATA_W-1:0] cell_data [CAPACITY];

  // Handshake and sequencing outputs
  always_comb begin
    req_stall = (state != ST_IDLE);
    accept    = req_valid && (state == ST_IDLE);
    fire      = (state == ST_EXEC) && !(rsp_valid && rsp_stall);
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_EXEC;
      ST_EXEC: if (fire) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Encode the first-match position
  always_comb begin
    hit_index = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first_vec[i]) hit_index = hit_index | IW'(i);
    end
  end

  assign found   = chain[CAPACITY];
  assign loc_bad = LCW'(loc_q) > LCW'(elem_count);
  assign is_full = (elem_count == CW'(CAPACITY));

  // Decide status, index and count for the request in flight
  always_comb begin
    status_next     = STAT_OK;
    index_next      = '0;
    elem_count_next = elem_count;
    cmd.cmp         = accept;
    cmd.upd         = 1'b0;
    cmd.ins         = 1'b0;
    cmd.del         = 1'b0;
    cmd.loc         = loc_q;
    cmd.key         = key;
    cmd.new_value   = value_q;
    case (mode_q)
      MODE_SEARCH, MODE_UPDATE: begin
        if (found) begin
          index_next = 6'(hit_index);
          cmd.upd    = fire && (mode_q == MODE_UPDATE);
        end else begin
          status_next = STAT_NOT_FOUND;
        end
      end
      MODE_INSERT: begin
        if (loc_bad) begin
          status_next = STAT_BAD_LOC;
        end else if (is_full) begin
          status_next = STAT_FULL;
        end else begin
          index_next      = 6'(loc_q);
          elem_count_next = elem_count + CW'(1);
          cmd.ins         = fire;
        end
      end
      MODE_DELETE: begin
        if (found) begin
          index_next      = 6'(hit_index);
          elem_count_next = elem_count - CW'(1);
          cmd.del         = fire;
        end else begin
          status_next = STAT_NOT_FOUND;
        end
      end
      default: status_next = STAT_NOT_FOUND;
    endcase
  end

  // Row of cells with first-match carry chain
  assign chain[0] = 1'b0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [DATA_W-1:0] lower_d, upper_d;
    assign lower_d = (g == 0) ? cell_data[g] : cell_data[(g == 0) ? 0 : g - 1];
    assign upper_d = (g == CAPACITY - 1) ? cell_data[g]
                                         : cell_data[(g == CAPACITY - 1) ? g : g + 1];
    atsid_cell #(
      .IDX (g),
      .CW  (CW)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .elem_count (elem_count),
      .lower      (lower_d),
      .upper      (upper_d),
      .before_in  (chain[g]),
      .before_out (chain[g+1]),
      .first      (first_vec[g]),
      .data       (cell_data[g])
    );
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      elem_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (fire) begin
        elem_count <= elem_count_next;
        rsp_valid  <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Request and response payload
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q  <= mode_t'(mode);
      value_q <= new_value;
      loc_q   <= location;
    end
    if (fire) begin
      status <= status_next;
      index  <= index_next;
      count  <= 7'(elem_count_next);
    end
  end

  // Count stays within the table
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    elem_count <= CW'(CAPACITY))
    else $error("element count exceeds capacity");

  // At most one cell claims the first match
  a_first_onehot: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC) |-> $onehot0(first_vec))
    else $error("more than one first-match cell");

  // A response only appears after an update cycle
  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == ST_EXEC))
    else $error("response without update cycle");

  // A successful insert grows the table by one
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (fire && mode_q == MODE_INSERT && status_next == STAT_OK)
      |=> elem_count == $past(elem_count) + CW'(1))
    else $error("insert did not grow count");

endmodule
